/* design/ppp_pkg.sv */
// ----------------------------------------------------------------------------
// ppp_pkg: shared types and constants
// Widths, register indexes and stage payload types for the projection core.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int CoordW  = 16;
  localparam int OutW    = 24;
  localparam int CfgW    = 64;
  localparam int CfgIdxW = 2;
  localparam int HW      = 35;  // homogeneous sum width, signed
  localparam int MagW    = 34;  // magnitude of a sum
  localparam int NumW    = MagW + 8;  // magnitude scaled by 256
  localparam int QW      = NumW;      // quotient width before clipping
  localparam int DivSteps = NumW;     // one quotient bit per stage step
  localparam int BitsPerStage = 6;
  localparam int DivStages = (DivSteps + BitsPerStage - 1) / BitsPerStage;

  localparam logic [CfgIdxW-1:0] RegRow0 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegRow1 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegRow2 = 2'd2;

  localparam logic [QW-1:0] PosMax = QW'(8388607);
  localparam logic [QW-1:0] NegMax = QW'(8388608);

  // State of one division lane.
  typedef struct packed {
    logic [NumW-1:0] num;   // remaining dividend bits, shifted out MSB first
    logic [MagW:0]   rem;   // partial remainder
    logic [QW-1:0]   quo;
  } div_lane_t;

  // Item state through the divider stages.
  typedef struct packed {
    div_lane_t       u;
    div_lane_t       v;
    logic [MagW-1:0] den;
    logic            neg_u;
    logic            neg_v;
    logic            dz;
  } div_item_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [MagW-1:0] den);
    logic [MagW:0] r;
    logic [MagW:0] d;
    div_lane_t o;
    r = {l.rem[MagW-1:0], l.num[NumW-1]};
    d = {1'b0, den};
    o.num = {l.num[NumW-2:0], 1'b0};
    if (r >= d) begin
      o.rem = r - d;
      o.quo = {l.quo[QW-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {l.quo[QW-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* design/ppp_stream_if.sv */
// ----------------------------------------------------------------------------
// ppp_point_if / ppp_image_if: valid/ready channels
// Input point channel and output image coordinate channel.
// ----------------------------------------------------------------------------
interface ppp_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppp_image_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] image_u;
  logic signed [23:0] image_v;
  logic               divisor_zero;
  logic               saturated;
  modport source (output valid, image_u, image_v, divisor_zero, saturated, input ready);
  modport sink (input valid, image_u, image_v, divisor_zero, saturated, output ready);
endinterface

/* design/ppp_dot.sv */
// ----------------------------------------------------------------------------
// ppp_dot: matrix-vector product
// Two stages: twelve registered terms (nine products and three offsets scaled
// by 256), then registered row-sum magnitudes, quotient signs and divisor-sum zero flag.
// ----------------------------------------------------------------------------
module ppp_dot import ppp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic signed [CoordW-1:0] z,
  input  logic [CfgW-1:0]          row0,
  input  logic [CfgW-1:0]          row1,
  input  logic [CfgW-1:0]          row2,
  output logic                     out_valid,
  output div_item_t                out_item
);

  logic signed [31:0] prod [3][4];
  logic               p_valid;
  logic [CfgW-1:0]    rows [3];

  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= in_valid;
    end
    if (adv) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= $signed(rows[r][15:0]) * x;
        prod[r][1] <= $signed(rows[r][31:16]) * y;
        prod[r][2] <= $signed(rows[r][47:32]) * z;
        prod[r][3] <= 32'($signed(rows[r][63:48])) <<< 8;
      end
    end
  end

  logic signed [HW-1:0] h [3];
  logic [MagW-1:0]      mag [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      h[r] = HW'(prod[r][0]) + HW'(prod[r][1]) + HW'(prod[r][2]) + HW'(prod[r][3]);
      mag[r] = h[r][HW-1] ? MagW'(-h[r]) : MagW'(h[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= p_valid;
    end
    if (adv) begin
      out_item.u.num <= {mag[0], 8'd0};
      out_item.u.rem <= '0;
      out_item.u.quo <= '0;
      out_item.v.num <= {mag[1], 8'd0};
      out_item.v.rem <= '0;
      out_item.v.quo <= '0;
      out_item.den   <= mag[2];
      out_item.neg_u <= h[0][HW-1] ^ h[2][HW-1];
      out_item.neg_v <= h[1][HW-1] ^ h[2][HW-1];
      out_item.dz    <= (h[2] == '0);
    end
  end

endmodule

/* design/ppp_div.sv */
// ----------------------------------------------------------------------------
// ppp_div: pipelined restoring divider
// Both quotients advance six bits per stage, one stage per cycle while adv is high,
// followed by a sign, clip and zero-divisor output stage.
// ----------------------------------------------------------------------------
module ppp_div import ppp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  div_item_t             in_item,
  output logic                  out_valid,
  output logic signed [OutW-1:0] u,
  output logic signed [OutW-1:0] v,
  output logic                  dz,
  output logic                  sat
);

  div_item_t stage [DivStages];
  logic      valid [DivStages];

  function automatic div_item_t run(div_item_t it, int n);
    div_item_t o;
    o = it;
    for (int k = 0; k < BitsPerStage; k++) begin
      if (k < n) begin
        o.u = div_step(o.u, o.den);
        o.v = div_step(o.v, o.den);
      end
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DivStages; s++) valid[s] <= 1'b0;
    end else if (adv) begin
      valid[0] <= in_valid;
      for (int s = 1; s < DivStages; s++) valid[s] <= valid[s-1];
    end
    if (adv) begin
      stage[0] <= run(in_item, BitsPerStage);
      for (int s = 1; s < DivStages; s++) begin
        stage[s] <= run(stage[s-1],
                        (DivSteps - s * BitsPerStage) < BitsPerStage ?
                        DivSteps - s * BitsPerStage : BitsPerStage);
      end
    end
  end

  div_item_t       fin;
  logic [QW-1:0]   qu, qv;
  logic            cu, cv;
  logic signed [OutW-1:0] ru, rv;

  assign fin = stage[DivStages-1];
  assign qu  = fin.u.quo;
  assign qv  = fin.v.quo;

  always_comb begin
    cu = fin.neg_u ? (qu > NegMax) : (qu > PosMax);
    cv = fin.neg_v ? (qv > NegMax) : (qv > PosMax);
    if (cu) ru = fin.neg_u ? OutW'(NegMax) : OutW'(PosMax);
    else    ru = fin.neg_u ? -OutW'(qu) : OutW'(qu);
    if (cv) rv = fin.neg_v ? OutW'(NegMax) : OutW'(PosMax);
    else    rv = fin.neg_v ? -OutW'(qv) : OutW'(qv);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= valid[DivStages-1];
    end
    if (adv) begin
      u   <= fin.dz ? '0 : ru;
      v   <= fin.dz ? '0 : rv;
      dz  <= fin.dz;
      sat <= !fin.dz && (cu || cv);
    end
  end

endmodule

/* design/perspective_point_projection_core.sv */
// ----------------------------------------------------------------------------
// perspective_point_projection_core: 3x4 homogeneous point projection
// Throughput: one point per cycle; the pipeline stalls as a whole when the
// output is not taken and the output register holds a finished result.
// Reset clears all valid bits and the matrix rows to zero.
// ----------------------------------------------------------------------------
module perspective_point_projection_core import ppp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data,
  ppp_point_if.sink          points,
  ppp_image_if.source        image
);

  logic [CfgW-1:0] row0, row1, row2;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0 <= '0;
      row1 <= '0;
      row2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegRow0: row0 <= cfg_data;
        RegRow1: row1 <= cfg_data;
        RegRow2: row2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances when the output register is empty or taken.
  logic adv;
  assign adv = !image.valid || image.ready;
  assign points.ready = adv;

  logic      d_valid;
  div_item_t d_item;

  ppp_dot u_dot (
    .clk, .rst, .adv,
    .in_valid (points.valid),
    .x (points.point_x), .y (points.point_y), .z (points.point_z),
    .row0, .row1, .row2,
    .out_valid (d_valid),
    .out_item  (d_item)
  );

  ppp_div u_div (
    .clk, .rst, .adv,
    .in_valid  (d_valid),
    .in_item   (d_item),
    .out_valid (image.valid),
    .u   (image.image_u),
    .v   (image.image_v),
    .dz  (image.divisor_zero),
    .sat (image.saturated)
  );

endmodule

/* design/ppp_checker.sv */
// ----------------------------------------------------------------------------
// ppp_checker: port-level checks
// Watches the output channel, input ready and result flag consistency.
// ----------------------------------------------------------------------------
module ppp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] u,
  input logic [23:0] v,
  input logic        dz,
  input logic        sat
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(u) && $stable(v))
    else $error("stalled result changed");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && dz |-> u == 24'd0 && v == 24'd0 && !sat)
    else $error("zero divisor result not cleared");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind perspective_point_projection_core ppp_checker u_chk (
  .clk, .rst,
  .in_ready  (points.ready),
  .out_valid (image.valid),
  .out_ready (image.ready),
  .u (image.image_u), .v (image.image_v),
  .dz (image.divisor_zero), .sat (image.saturated)
);

/* tb/perspective_point_projection_core_test.sv */
// ----------------------------------------------------------------------------
// perspective_point_projection_core_test: self-checking projection testbench
// Loads several projection matrices, streams directed and random points with
// random gaps on both channels, and compares each output transfer against a
// bit-accurate fixed-point projection computed inside the testbench.
// ----------------------------------------------------------------------------
module perspective_point_projection_core_test;
  import ppp_pkg::*;

  typedef struct packed {
    logic signed [23:0] u;
    logic signed [23:0] v;
    logic               dz;
    logic               sat;
  } image_t;

  // Index with no register behind it; writes to it are dropped.
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;

  ppp_point_if points ();
  ppp_image_if image ();

  perspective_point_projection_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .points(points.sink), .image(image.source)
  );

  logic [63:0] row_q [3];
  image_t pending_images[$];
  int errors = 0;
  bit stall_free = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic longint entry_of(logic [63:0] row, int c);
    logic signed [15:0] e;
    e = row[16*c +: 16];
    return longint'(e);
  endfunction

  function automatic longint dot_row(logic [63:0] row, longint x, longint y, longint z);
    return entry_of(row, 0) * x + entry_of(row, 1) * y + entry_of(row, 2) * z +
           entry_of(row, 3) * 256;
  endfunction

  function automatic logic [23:0] scaled_quotient(longint num, longint den, ref logic clip);
    longint unsigned q;
    longint unsigned mn;
    longint unsigned md;
    mn = num < 0 ? -num : num;
    md = den < 0 ? -den : den;
    q = (mn * 256) / md;
    if ((num < 0) != (den < 0)) begin
      if (q > 64'd8388608) begin
        clip = 1;
        return 24'h800000;
      end
      return 24'(-longint'(q));
    end
    if (q > 64'd8388607) begin
      clip = 1;
      return 24'h7FFFFF;
    end
    return 24'(q);
  endfunction

  function automatic image_t project_point(logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z);
    image_t r;
    longint h0;
    longint h1;
    longint h2;
    logic clip;
    h0 = dot_row(row_q[0], x, y, z);
    h1 = dot_row(row_q[1], x, y, z);
    h2 = dot_row(row_q[2], x, y, z);
    clip = 0;
    r = '0;
    if (h2 == 0) begin
      r.dz = 1;
    end else begin
      r.u = scaled_quotient(h0, h2, clip);
      r.v = scaled_quotient(h1, h2, clip);
    end
    r.sat = clip;
    return r;
  endfunction

  function automatic int gap_len();
    if (stall_free) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // Receiver side: random ready and the result check.
  initial begin
    image_t got;
    image_t want;
    int n;
    image.ready = 0;
    @(negedge clk);
    forever begin
      n = gap_len();
      if (n != 0) begin
        image.ready = 0;
        repeat (n) @(negedge clk);
      end
      image.ready = 1;
      @(posedge clk);
      if (image.valid && image.ready) begin
        got = '{image.image_u, image.image_v, image.divisor_zero, image.saturated};
        if (pending_images.size() == 0) begin
          $display("%0t: unexpected image %p", $time, got);
          errors++;
        end else begin
          want = pending_images.pop_front();
          if (got.u !== want.u) begin
            $display("%0t: image_u expected %h actual %h", $time, want.u, got.u);
            errors++;
          end
          if (got.v !== want.v) begin
            $display("%0t: image_v expected %h actual %h", $time, want.v, got.v);
            errors++;
          end
          if (got.dz !== want.dz) begin
            $display("%0t: divisor_zero expected %b actual %b", $time, want.dz, got.dz);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            errors++;
          end
        end
      end
      @(negedge clk);
    end
  end

  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    int n;
    n = gap_len();
    repeat (n) @(negedge clk);
    points.valid = 1;
    points.point_x = x;
    points.point_y = y;
    points.point_z = z;
    do @(posedge clk); while (!points.ready);
    pending_images.push_back(project_point(x, y, z));
    @(negedge clk);
    points.valid = 0;
  endtask

  task automatic write_row(logic [CfgIdxW-1:0] idx, logic [63:0] value);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 0;
    if (idx <= RegRow2) row_q[idx] = value;
  endtask

  task automatic wait_drained();
    while (pending_images.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_reset_matrix();
    // All rows are zero after reset, so every point divides by zero.
    send_point(16'h7FFF, 16'h8000, 16'h0000);
    send_point(16'h1234, 16'h0001, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_directed();
    write_row(RegRow0, 64'h0000_0000_0000_0100);
    write_row(RegRow1, 64'h0000_0000_0100_0000);
    write_row(RegRow2, 64'h0000_0100_0000_0000);
    write_row(RegUnused, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(16'h0100, 16'h0200, 16'h0100);
    send_point(16'hFF00, 16'h0100, 16'hFF00);
    send_point(16'h7FFF, 16'h8000, 16'h0001);
    send_point(16'h8000, 16'h7FFF, 16'hFFFF);
    send_point(16'h0001, 16'h0001, 16'h0000);
    send_point(16'h0000, 16'h0000, 16'h7FFF);
    send_point(16'h0000, 16'h0000, 16'h8000);
    wait_drained();
    write_row(RegRow0, 64'h8000_8000_8000_8000);
    write_row(RegRow1, 64'h7FFF_7FFF_7FFF_7FFF);
    write_row(RegRow2, 64'h0000_0000_0000_0001);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h0000, 16'h0000, 16'h0000);
    wait_drained();
    write_row(RegRow2, 64'hFFFF_FFFF_FFFF_FFFF);
    send_point(16'h8000, 16'h7FFF, 16'h0001);
    send_point(16'h0000, 16'h0000, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 9; phase++) begin
      stall_free = (phase == 4);
      write_row(RegRow0, phase == 8 ? 64'hFFFF_FFFF_FFFF_FFFF : rand_row());
      write_row(RegRow1, phase == 8 ? 64'h0 : rand_row());
      // Every third phase uses a divisor row with small x, zero y and random z and offset entries.
      if (phase % 3 == 0) write_row(RegRow2, {$urandom, 16'h0, 16'($urandom_range(0, 3))});
      else write_row(RegRow2, rand_row());
      if (phase == 5) write_row(RegUnused, rand_row());
      for (int i = 0; i < 150; i++) send_point(rand_coord(), rand_coord(), rand_coord());
      wait_drained();
    end
    stall_free = 0;
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    points.valid = 0;
    points.point_x = '0;
    points.point_y = '0;
    points.point_z = '0;
    row_q[0] = '0;
    row_q[1] = '0;
    row_q[2] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_reset_matrix();
    test_directed();
    test_random();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/ppp_pkg.sv
design/ppp_stream_if.sv
design/ppp_dot.sv
design/ppp_div.sv
design/perspective_point_projection_core.sv
design/ppp_checker.sv
tb/perspective_point_projection_core_test.sv
